>>> src/pie_pkg.sv
// ----------------------------------------------------------------------------
// pie_pkg
// Types, constants and fixed-point helpers shared by the particle integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package pie_pkg;

    localparam int DIV_STEPS     = 17;
    localparam int DIV_STAGES    = DIV_STEPS + 1;
    localparam int MOTION_STAGES = 6;
    localparam int ALIGN_STAGES  = DIV_STAGES - MOTION_STAGES;

    localparam logic [16:0] TIME_STEP_RESET = 17'd1092;
    localparam logic [23:0] GRAVITY_RESET   = 24'd642253;
    localparam logic [31:0] ROT_RATE        = 32'd90;
    localparam logic [30:0] MAX_AGE         = 31'h7FFF_FFFF;

    typedef enum logic [0:0] {
        CFG_TIME_STEP = 1'b0,
        CFG_GRAVITY   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [30:0] age_in;
        logic        [30:0] lifetime;
        logic        [23:0] drag_coef;
        logic signed [31:0] rotation_in;
        logic               last_particle;
    } t_particle;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] rotation;
        logic               last;
    } t_motion;

    typedef struct packed {
        logic        dead;
        logic [30:0] new_age;
        logic [16:0] opacity;
    } t_life;

    function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return t >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/pie_if.sv
// ----------------------------------------------------------------------------
// pie_if
// Valid/ready channels for particle records and integrated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pie_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [30:0] age_in;
    logic        [30:0] lifetime;
    logic        [23:0] drag_coef;
    logic signed [31:0] rotation_in;
    logic               last_particle;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age_in,
                    lifetime, drag_coef, rotation_in, last_particle, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age_in,
                  lifetime, drag_coef, rotation_in, last_particle, output ready);
endinterface

interface pie_out_if;
    logic               valid;
    logic               ready;
    logic               alive;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic        [30:0] new_age;
    logic        [16:0] opacity;
    logic signed [31:0] new_rotation;
    logic               frame_end;

    modport source (output valid, alive, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                    new_vel_y, new_vel_z, new_age, opacity, new_rotation, frame_end,
                    input ready);
    modport sink (input valid, alive, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                  new_vel_y, new_vel_z, new_age, opacity, new_rotation, frame_end,
                  output ready);
endinterface

`default_nettype wire

>>> src/pie_motion.sv
// ----------------------------------------------------------------------------
// pie_motion
// Six-stage pipeline for gravity, drag, velocity and position update.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_motion
    import pie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [16:0] i_dt,
    input  wire logic [23:0] i_grav,
    input  wire t_particle   i_item,
    output t_motion          o_res
);

    logic signed [18:0] dt_s;
    assign dt_s = $signed({2'b00, i_dt});

    // Stage 1: raw products of the per-item step.
    t_motion     r_s1;
    logic [40:0] r_s1_gd;
    logic [40:0] r_s1_dd;

    // Stage 2: vertical gravity and drag factor.
    t_motion            r_s2;
    logic signed [26:0] r_s2_f;

    // Stage 3: velocity times drag factor.
    t_motion            r_s3;
    logic signed [58:0] r_s3_px;
    logic signed [58:0] r_s3_py;
    logic signed [58:0] r_s3_pz;

    // Stage 4: new velocities.
    t_motion r_s4;

    // Stage 5: displacement products.
    t_motion            r_s5;
    logic signed [50:0] r_s5_qx;
    logic signed [50:0] r_s5_qy;
    logic signed [50:0] r_s5_qz;

    // Stage 6: new positions.
    t_motion r_s6;

    logic [40:0] rg_g;
    logic [40:0] rg_d;
    assign rg_g = (r_s1_gd + 41'h8000) >> 16;
    assign rg_d = (r_s1_dd + 41'h8000) >> 16;

    t_motion n_s2;
    t_motion n_s4;
    t_motion n_s6;

    always_comb begin
        n_s2       = r_s1;
        n_s2.vel_y = sat32(64'(r_s1.vel_y) - $signed({23'd0, rg_g}));

        n_s4       = r_s3;
        n_s4.vel_x = sat32(rnd16(64'(r_s3_px)));
        n_s4.vel_y = sat32(rnd16(64'(r_s3_py)));
        n_s4.vel_z = sat32(rnd16(64'(r_s3_pz)));

        n_s6       = r_s5;
        n_s6.pos_x = sat32(64'(r_s5.pos_x) + rnd16(64'(r_s5_qx)));
        n_s6.pos_y = sat32(64'(r_s5.pos_y) + rnd16(64'(r_s5_qy)));
        n_s6.pos_z = sat32(64'(r_s5.pos_z) + rnd16(64'(r_s5_qz)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1.pos_x    <= i_item.pos_x;
            r_s1.pos_y    <= i_item.pos_y;
            r_s1.pos_z    <= i_item.pos_z;
            r_s1.vel_x    <= i_item.vel_x;
            r_s1.vel_y    <= i_item.vel_y;
            r_s1.vel_z    <= i_item.vel_z;
            r_s1.rotation <= i_item.rotation_in + 32'(32'(i_dt) * ROT_RATE);
            r_s1.last     <= i_item.last_particle;
            r_s1_gd       <= 41'(i_grav) * 41'(i_dt);
            r_s1_dd       <= 41'(i_item.drag_coef) * 41'(i_dt);

            r_s2   <= n_s2;
            r_s2_f <= 27'sd65536 - $signed({2'b00, rg_d[24:0]});

            r_s3    <= r_s2;
            r_s3_px <= 59'(r_s2.vel_x) * 59'(r_s2_f);
            r_s3_py <= 59'(r_s2.vel_y) * 59'(r_s2_f);
            r_s3_pz <= 59'(r_s2.vel_z) * 59'(r_s2_f);

            r_s4 <= n_s4;

            r_s5    <= r_s4;
            r_s5_qx <= 51'(r_s4.vel_x) * 51'(dt_s);
            r_s5_qy <= 51'(r_s4.vel_y) * 51'(dt_s);
            r_s5_qz <= 51'(r_s4.vel_z) * 51'(dt_s);

            r_s6 <= n_s6;
        end
    end

    assign o_res = r_s6;

endmodule

`default_nettype wire

>>> src/pie_div.sv
// ----------------------------------------------------------------------------
// pie_div
// Age update and pipelined restoring divider for opacity, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_div
    import pie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [16:0] i_dt,
    input  wire logic [30:0] i_age,
    input  wire logic [30:0] i_life,
    output t_life            o_life
);

    logic [31:0] age_sum;
    logic [30:0] new_age;
    logic        dead;
    logic [30:0] remain;
    logic [48:0] numer;

    always_comb begin
        age_sum = 32'(i_age) + 32'(i_dt);
        new_age = (age_sum > 32'(MAX_AGE)) ? MAX_AGE : age_sum[30:0];
        dead    = (new_age >= i_life);
        remain  = dead ? 31'd0 : (i_life - new_age);
        numer   = 49'({remain, 17'd0}) + 49'(i_life);
    end

    logic [31:0]          r_rem  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_low  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo  [0:DIV_STEPS];
    logic [31:0]          r_den  [0:DIV_STEPS];
    logic [30:0]          r_age  [0:DIV_STEPS];
    logic                 r_dead [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= numer[48:17];
            r_low[0]  <= numer[16:0];
            r_quo[0]  <= '0;
            r_den[0]  <= {i_life, 1'b0};
            r_age[0]  <= new_age;
            r_dead[0] <= dead;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [32:0] shifted;
        logic        fits;
        assign shifted = {r_rem[k], r_low[k][DIV_STEPS-1]};
        assign fits    = (shifted >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= fits ? 32'(shifted - {1'b0, r_den[k]}) : shifted[31:0];
                r_low[k+1]  <= {r_low[k][DIV_STEPS-2:0], 1'b0};
                r_quo[k+1]  <= {r_quo[k][DIV_STEPS-2:0], fits};
                r_den[k+1]  <= r_den[k];
                r_age[k+1]  <= r_age[k];
                r_dead[k+1] <= r_dead[k];
            end
        end
    end

    assign o_life.dead    = r_dead[DIV_STEPS];
    assign o_life.new_age = r_age[DIV_STEPS];
    assign o_life.opacity = r_quo[DIV_STEPS];

endmodule

`default_nettype wire

>>> src/particle_integrate_step.sv
// ----------------------------------------------------------------------------
// particle_integrate_step
// One explicit Euler step with drag and aging for a stream of particles.
//
// Particle records arrive on i_item and one result per record leaves on
// o_result; both are valid/ready channels and a transfer happens when valid
// and ready are high at a clock edge. The user must write time step and
// gravity on the configuration port only while no particle is in flight;
// the block itself does not enforce this. Each record passes the age stage,
// which loads at the transfer edge, then the 17-stage opacity divider and
// the output register on its way to o_result. A new record is taken every
// cycle while the receiver does not stall the output.
// A dead particle gives zero position, velocity, opacity and rotation.
// Reset clears all valid bits and loads the default time step and gravity.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and i_item.ready goes low; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_integrate_step
    import pie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data,
    pie_in_if.sink           i_item,
    pie_out_if.source        o_result
);

    logic [16:0] r_time_step;
    logic [23:0] r_gravity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
            r_gravity   <= GRAVITY_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TIME_STEP: r_time_step <= i_cfg_data[16:0];
                CFG_GRAVITY:   r_gravity   <= i_cfg_data;
                default:       r_gravity   <= r_gravity;
            endcase
        end
    end

    logic r_out_valid;
    logic en;
    assign en           = !r_out_valid || o_result.ready;
    assign i_item.ready = en;

    t_particle item;
    always_comb begin
        item.pos_x         = i_item.pos_x;
        item.pos_y         = i_item.pos_y;
        item.pos_z         = i_item.pos_z;
        item.vel_x         = i_item.vel_x;
        item.vel_y         = i_item.vel_y;
        item.vel_z         = i_item.vel_z;
        item.age_in        = i_item.age_in;
        item.lifetime      = i_item.lifetime;
        item.drag_coef     = i_item.drag_coef;
        item.rotation_in   = i_item.rotation_in;
        item.last_particle = i_item.last_particle;
    end

    t_motion motion;
    t_life   life;

    pie_motion u_motion (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_dt   (r_time_step),
        .i_grav (r_gravity),
        .i_item (item),
        .o_res  (motion)
    );

    pie_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_dt   (r_time_step),
        .i_age  (i_item.age_in),
        .i_life (i_item.lifetime),
        .o_life (life)
    );

    logic [DIV_STAGES-1:0] r_vld;
    t_motion               r_dly [0:ALIGN_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_item.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= motion;
            for (int k = 1; k < ALIGN_STAGES; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    t_motion     r_out;
    logic        r_out_alive;
    logic [30:0] r_out_age;
    logic [16:0] r_out_opacity;
    t_motion     n_out;

    always_comb begin
        n_out      = life.dead ? '0 : r_dly[ALIGN_STAGES-1];
        n_out.last = r_dly[ALIGN_STAGES-1].last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out         <= n_out;
            r_out_alive   <= !life.dead;
            r_out_age     <= life.new_age;
            r_out_opacity <= life.dead ? 17'd0 : life.opacity;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.alive        = r_out_alive;
    assign o_result.new_pos_x    = r_out.pos_x;
    assign o_result.new_pos_y    = r_out.pos_y;
    assign o_result.new_pos_z    = r_out.pos_z;
    assign o_result.new_vel_x    = r_out.vel_x;
    assign o_result.new_vel_y    = r_out.vel_y;
    assign o_result.new_vel_z    = r_out.vel_z;
    assign o_result.new_age      = r_out_age;
    assign o_result.opacity      = r_out_opacity;
    assign o_result.new_rotation = r_out.rotation;
    assign o_result.frame_end    = r_out.last;

    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.alive) |->
        (o_result.opacity == 17'd0 && o_result.new_rotation == 32'sd0
         && o_result.new_vel_y == 32'sd0))
        else $error("dead particle carries nonzero fields");

    a_opacity_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.opacity <= 17'd65536))
        else $error("opacity above one");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[DIV_STAGES-1]) |=> r_out_valid)
        else $error("pipeline lost an item at the output register");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
